/* src/ppp_pkg.sv */
// Shared constants, codes and pipeline payload types of the pinhole projection block.
`default_nettype none
package ppp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int POSE_DEPTH = 12;
   // Quotient bits the divider resolves; anything at 2**DIV_STEPS or above saturates.
   localparam int DIV_STEPS  = 33;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_PROJECT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_FOCAL_X  = 2'd0,
      REG_FOCAL_Y  = 2'd1,
      REG_CENTER_X = 2'd2,
      REG_CENTER_Y = 2'd3
   } reg_index_type;

   // One division lane as it enters the divider.
   typedef struct packed {
      logic [63:0] num_mag;
      logic [31:0] den_mag;
      logic        neg;
      logic        num_neg;
      logic        ovf;
      logic        zero;
   } lane_type;

   // Partial state of one lane between divider stages.
   typedef struct packed {
      logic                 valid;
      logic [31:0]          rem;
      logic [63:0]          num_mag;
      logic [DIV_STEPS-1:0] quo;
      logic [31:0]          den_mag;
      logic                 neg;
      logic                 num_neg;
      logic                 ovf;
      logic                 zero;
   } div_stage_type;

endpackage
`default_nettype wire

/* src/pinhole_point_projection.sv */
// Top level of the pinhole projection pipeline: stream ports, camera registers, stage control.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata: index, pose value, x, y, z; tuser: cmd
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: pixel_u, pixel_v; tuser: depth_zero
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle while no result is stalled; each project item gives one result.
// Six transform and numerator stages, the 33 one-bit divider stages and the output
// register make 40 register stages, the first loaded at the transfer edge.
// Load items write the pose at their transfer and give no result.
// Reset clears the pose, the camera registers and all stage valid bits.
// The whole pipeline holds while a result waits on rsp_tready; req_tready follows it.
`default_nettype none
module pinhole_point_projection (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // pose_index, pose_value, point_x, point_y, point_z
   input  wire logic         req_tuser,  // cmd
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // pixel_u, pixel_v
   output logic              rsp_tuser,  // depth_zero
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import ppp_pkg::*;

   logic [30:0]        focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic               adv, accept, cam_valid, lane_valid;
   logic signed [31:0] cam_x, cam_y, cam_z;
   lane_type           lane_u, lane_v;
   logic               u_valid, v_valid, u_zero, v_zero;
   logic [31:0]        pixel_u, pixel_v;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= '0;
         focal_y_ff  <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_FOCAL_X:  focal_x_ff  <= csr_data[30:0];
            REG_FOCAL_Y:  focal_y_ff  <= csr_data[30:0];
            REG_CENTER_X: center_x_ff <= csr_data[30:0];
            REG_CENTER_Y: center_y_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   ppp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept && (cmd_type'(req_tuser) == CMD_PROJECT)),
      .load_en   (accept && (cmd_type'(req_tuser) == CMD_LOAD)),
      .load_idx  (req_tdata[3:0]),
      .load_val  (req_tdata[35:4]),
      .point_x   (req_tdata[67:36]),
      .point_y   (req_tdata[99:68]),
      .point_z   (req_tdata[131:100]),
      .cam_valid (cam_valid),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z)
   );

   ppp_numer u_numer (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cam_valid  (cam_valid),
      .cam_x      (cam_x),
      .cam_y      (cam_y),
      .cam_z      (cam_z),
      .focal_x    (focal_x_ff),
      .focal_y    (focal_y_ff),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .lane_valid (lane_valid),
      .lane_u     (lane_u),
      .lane_v     (lane_v)
   );

   ppp_div u_div_u (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lane_valid),
      .lane      (lane_u),
      .out_valid (u_valid),
      .result    (pixel_u),
      .zero      (u_zero)
   );

   ppp_div u_div_v (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lane_valid),
      .lane      (lane_v),
      .out_valid (v_valid),
      .result    (pixel_v),
      .zero      (v_zero)
   );

   // Both lanes move in lockstep, so either valid and zero flag serves.
   assign rsp_tvalid = u_valid && v_valid;
   assign rsp_tuser  = u_zero && v_zero;
   assign rsp_tdata  = {pixel_v, pixel_u};
endmodule
`default_nettype wire

/* src/ppp_xform.sv */
// Pose store and the three stages that map a world point to camera coordinates.
`default_nettype none
module ppp_xform (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic               load_en,
   input  wire logic [3:0]         load_idx,
   input  wire logic signed [31:0] load_val,
   input  wire logic signed [31:0] point_x,
   input  wire logic signed [31:0] point_y,
   input  wire logic signed [31:0] point_z,
   output logic                    cam_valid,
   output logic signed [31:0]      cam_x,
   output logic signed [31:0]      cam_y,
   output logic signed [31:0]      cam_z
);
   import ppp_pkg::*;

   logic signed [31:0] pose_ff [POSE_DEPTH];
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [31:0] pt_ff [3];
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] t_ff [3];
   logic signed [31:0] cam_ff [3];
   logic signed [63:0] prod_in [9];
   logic signed [31:0] cam_in [3];
   logic signed [63:0] acc [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POSE_DEPTH; i++) pose_ff[i] <= '0;
      end else if (load_en && (load_idx < 4'(POSE_DEPTH))) begin
         pose_ff[load_idx] <= load_val;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = 64'(pose_ff[r*4+c]) * 64'(pt_ff[c]);
         end
      end
      for (int r = 0; r < 3; r++) begin
         // Arithmetic shift gives the floor of each product.
         acc[r] = 64'(t_ff[r]) + (prod_ff[r*3] >>> FRAC_BITS)
                + (prod_ff[r*3+1] >>> FRAC_BITS) + (prod_ff[r*3+2] >>> FRAC_BITS);
         if (acc[r] > 64'sd2147483647) begin
            cam_in[r] = 32'sh7FFFFFFF;
         end else if (acc[r] < -64'sd2147483648) begin
            cam_in[r] = 32'sh80000000;
         end else begin
            cam_in[r] = acc[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= point_x;
         pt_ff[1] <= point_y;
         pt_ff[2] <= point_z;
         for (int i = 0; i < 9; i++) prod_ff[i] <= prod_in[i];
         for (int r = 0; r < 3; r++) begin
            t_ff[r]   <= pose_ff[r*4+3];
            cam_ff[r] <= cam_in[r];
         end
      end
   end

   assign cam_valid = v3_ff;
   assign cam_x     = cam_ff[0];
   assign cam_y     = cam_ff[1];
   assign cam_z     = cam_ff[2];
endmodule
`default_nettype wire

/* src/ppp_numer.sv */
// Numerator products, their sums and the sign and magnitude split for both divider lanes.
`default_nettype none
module ppp_numer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               cam_valid,
   input  wire logic signed [31:0] cam_x,
   input  wire logic signed [31:0] cam_y,
   input  wire logic signed [31:0] cam_z,
   input  wire logic [30:0]        focal_x,
   input  wire logic [30:0]        focal_y,
   input  wire logic [30:0]        center_x,
   input  wire logic [30:0]        center_y,
   output logic                    lane_valid,
   output ppp_pkg::lane_type       lane_u,
   output ppp_pkg::lane_type       lane_v
);
   import ppp_pkg::*;

   logic               v4_ff, v5_ff, v6_ff;
   logic signed [63:0] pfx_ff, pcx_ff, pfy_ff, pcy_ff;
   logic signed [31:0] z4_ff, z5_ff;
   logic signed [63:0] nu_ff, nv_ff;
   lane_type           lu_ff, lv_ff, lu_in, lv_in;
   logic [31:0]        den_mag;

   function automatic lane_type make_lane(logic signed [63:0] num, logic signed [31:0] z,
                                          logic [31:0] dm);
      lane_type l;
      l.num_mag = num[63] ? 64'(-num) : 64'(num);
      l.den_mag = dm;
      l.num_neg = num[63];
      l.neg     = num[63] != z[31];
      l.zero    = (z == 32'sd0);
      l.ovf     = {1'b0, l.num_mag} >= {dm, DIV_STEPS'(0)};
      return l;
   endfunction

   assign den_mag = z5_ff[31] ? 32'(-z5_ff) : 32'(z5_ff);

   always_comb begin
      lu_in = make_lane(nu_ff, z5_ff, den_mag);
      lv_in = make_lane(nv_ff, z5_ff, den_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= cam_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pfx_ff <= 64'($signed({1'b0, focal_x})) * 64'(cam_x);
         pcx_ff <= 64'($signed({1'b0, center_x})) * 64'(cam_z);
         pfy_ff <= 64'($signed({1'b0, focal_y})) * 64'(cam_y);
         pcy_ff <= 64'($signed({1'b0, center_y})) * 64'(cam_z);
         z4_ff  <= cam_z;
         nu_ff  <= pfx_ff + pcx_ff;
         nv_ff  <= pfy_ff + pcy_ff;
         z5_ff  <= z4_ff;
         lu_ff  <= lu_in;
         lv_ff  <= lv_in;
      end
   end

   assign lane_valid = v6_ff;
   assign lane_u     = lu_ff;
   assign lane_v     = lv_ff;
endmodule
`default_nettype wire

/* src/ppp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation at the end.
`default_nettype none
module ppp_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  ppp_pkg::lane_type lane,
   output logic              out_valid,
   output logic [31:0]       result,
   output logic              zero
);
   import ppp_pkg::*;

   div_stage_type st_ff [DIV_STEPS];
   div_stage_type init;
   logic          res_valid_ff, res_zero_ff;
   logic [31:0]   res_ff, res_in;
   div_stage_type last;

   always_comb begin
      init.valid   = in_valid;
      // Unless the lane is flagged ovf, the quotient is below 2**DIV_STEPS, so the top bits are below the divisor.
      init.rem     = {1'b0, lane.num_mag[63:DIV_STEPS]};
      init.num_mag = lane.num_mag;
      init.quo     = '0;
      init.den_mag = lane.den_mag;
      init.neg     = lane.neg;
      init.num_neg = lane.num_neg;
      init.ovf     = lane.ovf;
      init.zero    = lane.zero;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      div_stage_type src, nxt;
      logic [32:0]   sh;
      if (k == 0) begin : g_first
         assign src = init;
      end else begin : g_next
         assign src = st_ff[k-1];
      end
      always_comb begin
         nxt = src;
         sh  = {src.rem, src.num_mag[DIV_STEPS-1-k]};
         if (sh >= {1'b0, src.den_mag}) begin
            nxt.rem                  = 32'(sh - {1'b0, src.den_mag});
            nxt.quo[DIV_STEPS-1-k] = 1'b1;
         end else begin
            nxt.rem = sh[31:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (adv) begin
            st_ff[k] <= nxt;
         end
      end
   end

   assign last = st_ff[DIV_STEPS-1];

   always_comb begin
      if (last.zero) begin
         res_in = last.num_neg ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (last.ovf) begin
         res_in = last.neg ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (last.neg) begin
         res_in = (last.quo > DIV_STEPS'(33'h080000000)) ? 32'h80000000
                                                          : 32'(-last.quo);
      end else begin
         res_in = (last.quo > DIV_STEPS'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : last.quo[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (adv) begin
         res_valid_ff <= last.valid;
      end
      if (adv) begin
         res_ff      <= res_in;
         res_zero_ff <= last.zero;
      end
   end

   assign out_valid = res_valid_ff;
   assign result    = res_ff;
   assign zero      = res_zero_ff;
endmodule
`default_nettype wire

/* src/ppp_checker.sv */
// Port-level assertions for the pinhole projection block, bound to its top level.
`default_nettype none
module ppp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [135:0] req_tdata,
   input wire logic         req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         csr_valid,
   input wire logic         csr_ready,
   input wire logic [1:0]   csr_index,
   input wire logic [31:0]  csr_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[31:0] == 32'h7FFFFFFF || rsp_tdata[31:0] == 32'h80000000) &&
         (rsp_tdata[63:32] == 32'h7FFFFFFF || rsp_tdata[63:32] == 32'h80000000))
      else $error("zero depth result not saturated");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);
`default_nettype wire

/* verif/pinhole_point_projection_checker.sv */
// Checker for the pinhole projection block: watches all channels, predicts and compares results.
module pinhole_point_projection_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [135:0] req_tdata,  // pose_index, pose_value, point_x, point_y, point_z
   input  wire logic         req_tuser,  // cmd
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,  // pixel_u, pixel_v
   input  wire logic         rsp_tuser,  // depth_zero
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                failures,
   output int                pixels_pending
);
   import ppp_pkg::*;

   typedef struct {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic               depth_zero;
   } pixel_type;

   logic signed [31:0] pose[POSE_DEPTH];
   logic [30:0]        focal_x, focal_y, center_x, center_y;
   pixel_type          pixel_queue[$];

   initial failures = 0;
   assign pixels_pending = pixel_queue.size();

   function automatic longint cam_axis(int row, longint p[3]);
      longint acc;
      acc = longint'(pose[row*4+3]);
      for (int j = 0; j < 3; j++) begin
         acc += (longint'(pose[row*4+j]) * p[j]) >>> FRAC_BITS;
      end
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc;
   endfunction

   function automatic logic signed [31:0] image_coord(logic [30:0] f, logic [30:0] c,
                                                      longint a, longint zc);
      longint num, q;
      num = longint'({33'd0, f}) * a + longint'({33'd0, c}) * zc;
      if (zc == 0) begin
         q = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
         // Signed division truncates toward zero.
         q = num / zc;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      return q[31:0];
   endfunction

   function automatic pixel_type project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint    p[3];
      longint    xc, yc, zc;
      pixel_type r;
      p[0] = longint'(signed'(x));
      p[1] = longint'(signed'(y));
      p[2] = longint'(signed'(z));
      xc = cam_axis(0, p);
      yc = cam_axis(1, p);
      zc = cam_axis(2, p);
      r.pixel_u    = image_coord(focal_x, center_x, xc, zc);
      r.pixel_v    = image_coord(focal_y, center_y, yc, zc);
      r.depth_zero = (zc == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         foreach (pose[i]) pose[i] <= '0;
         focal_x  <= '0;
         focal_y  <= '0;
         center_x <= '0;
         center_y <= '0;
         pixel_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_FOCAL_X:  focal_x  <= csr_data[30:0];
               REG_FOCAL_Y:  focal_y  <= csr_data[30:0];
               REG_CENTER_X: center_x <= csr_data[30:0];
               REG_CENTER_Y: center_y <= csr_data[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser) == CMD_LOAD) begin
               // Indices past the last pose element are dropped.
               if (req_tdata[3:0] < POSE_DEPTH) pose[req_tdata[3:0]] <= req_tdata[35:4];
            end else begin
               pixel_queue.push_back(project_point(req_tdata[67:36], req_tdata[99:68],
                                                   req_tdata[131:100]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected result transfer: pixel_u %h pixel_v %h depth_zero %b",
                      rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
               failures++;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_tdata[31:0] !== want.pixel_u) begin
                  $error("pixel_u: expected %h, actual %h", want.pixel_u, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[63:32] !== want.pixel_v) begin
                  $error("pixel_v: expected %h, actual %h", want.pixel_v, rsp_tdata[63:32]);
                  failures++;
               end
               if (rsp_tuser !== want.depth_zero) begin
                  $error("depth_zero: expected %b, actual %b", want.depth_zero, rsp_tuser);
                  failures++;
               end
            end
         end
      end
   end

endmodule

/* verif/tb_pinhole_point_projection.sv */
// Testbench top for the pinhole projection block: stimulus, flow control and verdict.
module tb_pinhole_point_projection;
   import ppp_pkg::*;

   localparam int ONE        = 1 << FRAC_BITS;
   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [3:0]  req_index = '0;
   logic [31:0] req_value = '0, req_x = '0, req_y = '0, req_z = '0;
   logic [135:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          failures, pixels_pending;
   int          burst_left = 0;
   int          idle_cycles = 0;

   assign req_tdata = {4'd0, req_z, req_y, req_x, req_value, req_index};

   pinhole_point_projection DUT (.*);
   pinhole_point_projection_checker checker_i (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver: stall pattern is redrawn at random from three modes, plus one long hold-off.
   initial begin
      int cyc, mode, hold;
      cyc = 0;
      mode = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 2);
         if (cyc == 700) hold = 400;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               default: rsp_tready <= (cyc % 5 != 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any transfer.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(cmd_type cmd, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_index  <= idx;
      req_value  <= val;
      req_x      <= x;
      req_y      <= y;
      req_z      <= z;
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write of a group.
   task automatic write_reg(reg_index_type idx, logic [30:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= {1'($urandom_range(0, 1)), val};
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   function automatic logic [31:0] coord_value();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 200 * ONE) - 100 * ONE;
   endfunction

   task automatic random_items(int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(CMD_LOAD, 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 9) == 0) ? $urandom
                                                  : $urandom_range(0, 2 * ONE) - ONE,
                      $urandom, $urandom, $urandom);
         end else begin
            send_item(CMD_PROJECT, 4'($urandom), $urandom,
                      coord_value(), coord_value(), coord_value());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset pose is all zero, so depth is zero and outputs saturate.
      send_item(CMD_PROJECT, 4'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'd0);
      wait_idle();
      write_reg(REG_FOCAL_X, 31'(800 * ONE));
      write_reg(REG_FOCAL_Y, 31'(600 * ONE));
      write_reg(REG_CENTER_X, 31'(320 * ONE));
      write_reg(REG_CENTER_Y, 31'(240 * ONE));
      csr_valid <= 1'b0;

      // Identity rotation with the camera five units back.
      send_item(CMD_LOAD, 4'd0, ONE, 0, 0, 0);
      send_item(CMD_LOAD, 4'd5, ONE, 0, 0, 0);
      send_item(CMD_LOAD, 4'd10, ONE, 0, 0, 0);
      send_item(CMD_LOAD, 4'd11, 5 * ONE, 0, 0, 0);
      // Out-of-range pose indices are ignored.
      send_item(CMD_LOAD, 4'd12, 32'hFFFFFFFF, 0, 0, 0);
      send_item(CMD_LOAD, 4'd15, 32'h80000000, 0, 0, 0);
      send_item(CMD_PROJECT, 4'd0, 32'd0, ONE, -ONE, 0);
      send_item(CMD_PROJECT, 4'hF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(CMD_PROJECT, 4'd0, 32'd0, 32'h80000000, 32'h80000000, 32'h80000000);
      // Point on the camera plane: zero depth with both signs of numerator.
      send_item(CMD_PROJECT, 4'd0, 32'd0, ONE, -ONE, -5 * ONE);
      send_item(CMD_PROJECT, 4'd0, 32'd0, -ONE, ONE, -5 * ONE);
      send_item(CMD_PROJECT, 4'd0, 32'd0, 3 * ONE, 2 * ONE, -10 * ONE);
      // Extreme pose values make the camera coordinates saturate.
      send_item(CMD_LOAD, 4'd1, 32'h7FFFFFFF, 0, 0, 0);
      send_item(CMD_LOAD, 4'd3, 32'h80000000, 0, 0, 0);
      send_item(CMD_PROJECT, 4'd0, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, ONE);
      send_item(CMD_PROJECT, 4'd0, 32'd0, 32'h80000000, 32'h80000000, ONE);
      // Tiny depth gives a quotient far past 32 bits.
      send_item(CMD_LOAD, 4'd11, 32'd1, 0, 0, 0);
      send_item(CMD_PROJECT, 4'd0, 32'd0, 0, 0, 0);
      send_item(CMD_LOAD, 4'd1, 32'd0, 0, 0, 0);
      send_item(CMD_LOAD, 4'd3, 32'd0, 0, 0, 0);
      send_item(CMD_LOAD, 4'd11, 5 * ONE, 0, 0, 0);
      random_items(250);

      wait_idle();
      write_reg(REG_FOCAL_X, 31'd0);
      write_reg(REG_FOCAL_Y, 31'd0);
      write_reg(REG_CENTER_X, 31'd0);
      write_reg(REG_CENTER_Y, 31'd0);
      csr_valid <= 1'b0;
      random_items(150);

      wait_idle();
      write_reg(REG_FOCAL_X, 31'h7FFFFFFF);
      write_reg(REG_FOCAL_Y, 31'h7FFFFFFF);
      write_reg(REG_CENTER_X, 31'h7FFFFFFF);
      write_reg(REG_CENTER_Y, 31'h7FFFFFFF);
      csr_valid <= 1'b0;
      random_items(150);

      wait_idle();
      write_reg(REG_FOCAL_X, 31'($urandom));
      write_reg(REG_FOCAL_Y, 31'($urandom_range(0, 2000 * ONE)));
      write_reg(REG_CENTER_X, 31'($urandom_range(0, 1000 * ONE)));
      write_reg(REG_CENTER_Y, 31'($urandom));
      csr_valid <= 1'b0;
      random_items(200);

      req_tvalid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ppp_pkg.sv
src/ppp_xform.sv
src/ppp_numer.sv
src/ppp_div.sv
src/pinhole_point_projection.sv
src/ppp_checker.sv
verif/pinhole_point_projection_checker.sv
verif/tb_pinhole_point_projection.sv
